>>> rtl/core/modexp_pkg.sv
// shared constants and control types for the modular exponentiation block
`default_nettype none
package modexp_pkg;

    // field widths
    localparam int RES_W    = 30;
    localparam int BASE_W   = 30;
    localparam int EXP_IN_W = 32;
    localparam int PROD_W   = 2 * RES_W;

    // default number of exponent bits taken part in
    localparam int EXP_WIDTH_DEF = 32;

    // modulus and barrett constant floor(2^60 / prime)
    localparam logic [RES_W-1:0] PRIME     = 30'd998244353;
    localparam logic [31:0]      PRIME2    = 32'd1996488706;
    localparam int               MU_W      = 31;
    localparam logic [MU_W-1:0]  MU        = MU_W'((64'd1 << 60) / 64'd998244353);
    localparam int               BAR_SHIFT = 28;

    // pipeline destination tags
    localparam logic TAG_BASE = 1'b0;
    localparam logic TAG_ACC  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic issue_sq;
        logic issue_mul;
        logic shift_exp;
        logic out_load;
    } modexp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } modexp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/modexp_mulmod.sv
// pipelined barrett modular multiplier, one operation issued per cycle
`default_nettype none
module modexp_mulmod (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    input  wire logic                         in_tag,
    input  wire logic [modexp_pkg::RES_W-1:0] in_a,
    input  wire logic [modexp_pkg::RES_W-1:0] in_b,
    output logic                              out_valid,
    output logic                              out_tag,
    output logic [modexp_pkg::RES_W-1:0]      out_res
);

    localparam int PW = modexp_pkg::PROD_W;
    localparam int HW = PW - modexp_pkg::BAR_SHIFT;
    localparam int TW = HW + modexp_pkg::MU_W;
    localparam int QW = TW - 32;

    logic [2:0]          vld_reg, vld_next;
    logic [2:0]          tag_reg;
    logic [PW-1:0]       prod_reg;
    logic [TW-1:0]       t_reg;
    logic [31:0]         xlo2_reg;
    logic [31:0]         xlo3_reg;
    logic [31:0]         qp_reg;
    logic [QW+modexp_pkg::RES_W-1:0] qp_full;
    logic [31:0]         rem;
    logic [31:0]         rem_m1;
    logic [31:0]         rem_m2;

    assign vld_next = {vld_reg[1:0], in_valid};
    assign qp_full  = (QW+modexp_pkg::RES_W)'(t_reg[TW-1:32])
                    * (QW+modexp_pkg::RES_W)'(modexp_pkg::PRIME);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= {tag_reg[1:0], in_tag};
        // stage 1: full product
        prod_reg <= PW'(in_a) * PW'(in_b);
        // stage 2: quotient estimate
        t_reg    <= TW'(prod_reg[PW-1:modexp_pkg::BAR_SHIFT]) * TW'(modexp_pkg::MU);
        xlo2_reg <= prod_reg[31:0];
        // stage 3: quotient times modulus, low word only
        qp_reg   <= qp_full[31:0];
        xlo3_reg <= xlo2_reg;
    end

    // remainder is below three times the modulus
    always_comb begin
        rem    = xlo3_reg - qp_reg;
        rem_m1 = rem - 32'(modexp_pkg::PRIME);
        rem_m2 = rem - modexp_pkg::PRIME2;
        if (rem >= modexp_pkg::PRIME2) begin
            out_res = rem_m2[modexp_pkg::RES_W-1:0];
        end else if (rem >= 32'(modexp_pkg::PRIME)) begin
            out_res = rem_m1[modexp_pkg::RES_W-1:0];
        end else begin
            out_res = rem[modexp_pkg::RES_W-1:0];
        end
    end

    assign out_valid = vld_reg[2];
    assign out_tag   = tag_reg[2];

endmodule
`default_nettype wire

>>> rtl/core/modexp_datapath.sv
// operand, accumulator, exponent and result registers around the multiplier
`default_nettype none
module modexp_datapath #(
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire modexp_pkg::modexp_cmd_t         cmd,
    output modexp_pkg::modexp_status_t           status,
    input  wire logic [modexp_pkg::BASE_W-1:0]   s_base_value,
    input  wire logic [modexp_pkg::EXP_IN_W-1:0] s_exponent_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [modexp_pkg::RES_W-1:0]         m_power_residue
);

    logic [modexp_pkg::RES_W-1:0] base_reg, base_next;
    logic [modexp_pkg::RES_W-1:0] acc_reg, acc_next;
    logic [EXP_WIDTH-1:0]         exp_reg, exp_next;
    logic [modexp_pkg::RES_W-1:0] out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;
    logic [63:0]                  exp_ext;
    logic [modexp_pkg::BASE_W-1:0] base_sub;

    logic                         mm_in_valid;
    logic                         mm_in_tag;
    logic [modexp_pkg::RES_W-1:0] mm_in_a;
    logic                         mm_out_valid;
    logic                         mm_out_tag;
    logic [modexp_pkg::RES_W-1:0] mm_out_res;

    // square always issues, the multiply only for a set exponent bit
    assign mm_in_valid = cmd.issue_sq | (cmd.issue_mul & exp_reg[0]);
    assign mm_in_tag   = cmd.issue_mul ? modexp_pkg::TAG_ACC : modexp_pkg::TAG_BASE;
    assign mm_in_a     = cmd.issue_mul ? acc_reg : base_reg;

    modexp_mulmod u_mulmod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (mm_in_valid),
        .in_tag   (mm_in_tag),
        .in_a     (mm_in_a),
        .in_b     (base_reg),
        .out_valid(mm_out_valid),
        .out_tag  (mm_out_tag),
        .out_res  (mm_out_res)
    );

    assign exp_ext  = {32'd0, s_exponent_value};
    assign base_sub = s_base_value - modexp_pkg::PRIME;

    always_comb begin
        base_next = base_reg;
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        if (cmd.load) begin
            // base is below twice the modulus
            base_next = (s_base_value >= modexp_pkg::PRIME) ? base_sub : s_base_value;
            acc_next  = modexp_pkg::RES_W'(1);
            exp_next  = exp_ext[EXP_WIDTH-1:0];
        end else begin
            if (mm_out_valid && mm_out_tag == modexp_pkg::TAG_BASE) begin
                base_next = mm_out_res;
            end
            if (mm_out_valid && mm_out_tag == modexp_pkg::TAG_ACC) begin
                acc_next = mm_out_res;
            end
            if (cmd.shift_exp) begin
                exp_next = exp_reg >> 1;
            end
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_next       = acc_reg;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
        out_reg  <= out_next;
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_power_residue = out_reg;

endmodule
`default_nettype wire

>>> rtl/core/modexp_ctrl.sv
// sequencer for square-and-multiply over the exponent bits
`default_nettype none
module modexp_ctrl #(
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    output modexp_pkg::modexp_cmd_t         cmd,
    input  wire modexp_pkg::modexp_status_t status
);

    localparam int CNT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(EXP_WIDTH - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [1:0] PH_SQ  = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_END = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] bit_reg, bit_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_RUN;
                    phase_next = PH_SQ;
                    bit_next   = '0;
                end
            end
            ST_RUN: begin
                cmd.issue_sq  = (phase_reg == PH_SQ);
                cmd.issue_mul = (phase_reg == PH_MUL);
                cmd.shift_exp = (phase_reg == PH_MUL);
                phase_next    = phase_reg + 2'd1;
                if (phase_reg == PH_END) begin
                    if (bit_reg == LAST_BIT) begin
                        state_next = ST_DRAIN;
                    end else begin
                        bit_next = bit_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SQ;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/modular_exponentiation.sv
// modular exponentiation top level: base^exponent mod 998244353
// one transaction at a time: a new one is taken only after the previous result is loaded into
// the output register, and each exponent bit loops through the barrett multiplier
// a new input transaction is taken while the previous result waits in the output register
// reset: synchronous active-low aresetn clears the sequencer and the output valid
`default_nettype none
module modular_exponentiation #(
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input transaction channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [modexp_pkg::BASE_W-1:0]   s_base_value,
    input  wire logic [modexp_pkg::EXP_IN_W-1:0] s_exponent_value,
    // result transaction channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [modexp_pkg::RES_W-1:0]         m_power_residue
);

    // command and status between sequencer and datapath
    modexp_pkg::modexp_cmd_t    cmd;
    modexp_pkg::modexp_status_t status;

    // sequencer: one square and one conditional multiply per exponent bit
    modexp_ctrl #(
        .EXP_WIDTH(EXP_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath: base, accumulator, exponent shifter, multiplier and output register
    modexp_datapath #(
        .EXP_WIDTH(EXP_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_base_value    (s_base_value),
        .s_exponent_value(s_exponent_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_power_residue (m_power_residue)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb_modular_exponentiation.sv
// self-checking testbench for modular_exponentiation: directed, back-pressure and random powers
module tb_modular_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    // package constants used here
    localparam int               BASE_W        = modexp_pkg::BASE_W;
    localparam int               EXP_IN_W      = modexp_pkg::EXP_IN_W;
    localparam int               RES_W         = modexp_pkg::RES_W;
    localparam int               EXP_WIDTH_DEF = modexp_pkg::EXP_WIDTH_DEF;
    localparam logic [RES_W-1:0] PRIME         = modexp_pkg::PRIME;

    // time one input transaction takes, over every exponent bit plus load and output
    localparam int          ITEM_CYCLES     = 4 * EXP_WIDTH_DEF + 3;
    localparam int          DRAIN_CYCLES    = ITEM_CYCLES + 10;
    localparam int          RESET_CYCLES    = 11;
    localparam int          MAX_GAP         = 300;
    localparam int          HOLD_OFF_CYCLES = 600;
    localparam int          BACKLOG_ITEMS   = 12;
    localparam int          RANDOM_ITEMS    = 1870;
    // slowest legal wait between two transactions, taken several times over
    localparam int          WATCHDOG_LIMIT  = 4 * (HOLD_OFF_CYCLES + 2 * ITEM_CYCLES + MAX_GAP);
    localparam int unsigned BASE_MAX        = (1 << BASE_W) - 1;
    localparam logic [EXP_IN_W-1:0] EXP_MAX = '1;

    // one accepted input together with the residue it must produce
    typedef struct {
        logic [BASE_W-1:0]   base;
        logic [EXP_IN_W-1:0] expo;
        logic [RES_W-1:0]    residue;
    } power_case_t;

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [BASE_W-1:0]   s_base_value     = '0;
    logic [EXP_IN_W-1:0] s_exponent_value = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [RES_W-1:0]    m_power_residue;

    power_case_t pending_powers[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    // long hold-off handshake between the test sequence and the receiver
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;

    always #6 aclk = ~aclk;

    modular_exponentiation dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_base_value     (s_base_value),
        .s_exponent_value (s_exponent_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_power_residue  (m_power_residue)
    );

    // square-and-multiply from the lowest exponent bit, base reduced first
    function automatic logic [RES_W-1:0] power_mod_prime(input logic [BASE_W-1:0] base,
                                                         input logic [EXP_IN_W-1:0] expo);
        logic [63:0] square;
        logic [63:0] product;
        square  = 64'(base) % 64'(PRIME);
        product = 64'd1;
        for (int k = 0; k < EXP_WIDTH_DEF && k < EXP_IN_W; k++) begin
            if (expo[k]) begin
                product = (product * square) % 64'(PRIME);
            end
            square = (square * square) % 64'(PRIME);
        end
        return RES_W'(product);
    endfunction

    // bases: tiny, just below the prime, at or above the prime, multiples of it, anything
    function automatic logic [BASE_W-1:0] random_base();
        logic [BASE_W-1:0] value;
        case ($urandom_range(0, 5))
            0: value = BASE_W'($urandom_range(0, 15));
            1: value = PRIME - BASE_W'($urandom_range(1, 16));
            2: value = PRIME + BASE_W'($urandom_range(0, BASE_MAX - int'(PRIME)));
            3: value = ($urandom_range(0, 1) != 0) ? PRIME : '0;
            default: value = BASE_W'($urandom());
        endcase
        return value;
    endfunction

    // exponents: small, one-hot, one-cold, near multiples of the group order, anything
    function automatic logic [EXP_IN_W-1:0] random_exponent();
        logic [EXP_IN_W-1:0] value;
        case ($urandom_range(0, 5))
            0: value = EXP_IN_W'($urandom_range(0, 64));
            1: value = EXP_IN_W'(1) << $urandom_range(0, EXP_IN_W - 1);
            2: value = ~(EXP_IN_W'(1) << $urandom_range(0, EXP_IN_W - 1));
            3: begin
                value = EXP_IN_W'(PRIME) - EXP_IN_W'(1);
                value = value * EXP_IN_W'($urandom_range(1, 4))
                        - EXP_IN_W'($urandom_range(0, 1));
            end
            default: value = EXP_IN_W'($urandom());
        endcase
        return value;
    endfunction

    // offer one transaction and hold it until the block takes it; valid stays high afterwards
    task automatic send_power(input logic [BASE_W-1:0] base, input logic [EXP_IN_W-1:0] expo);
        s_valid          <= 1'b1;
        s_base_value     <= base;
        s_exponent_value <= expo;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and hold it low for the requested gap
    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // extremes of both fields and every special case of the arithmetic
    task automatic test_directed_powers();
        logic [BASE_W-1:0] bases [21] = '{
            '0, PRIME, BASE_W'(BASE_MAX), '0, PRIME, PRIME, 30'd1, 30'd2, 30'd2, 30'd3,
            PRIME - 30'd1, PRIME - 30'd1, PRIME - 30'd1, PRIME + 30'd1, BASE_W'(BASE_MAX),
            BASE_W'(BASE_MAX), 30'd12345, 30'd12345, 30'd2, PRIME + 30'd2,
            BASE_W'(BASE_MAX - 1)
        };
        logic [EXP_IN_W-1:0] expos [21] = '{
            '0, '0, '0, 32'd1, 32'd1, EXP_MAX, EXP_MAX, 32'd1, 32'd29, 32'd2,
            32'd1, 32'd2, EXP_MAX, EXP_MAX, 32'd1,
            EXP_MAX, 32'd998244352, 32'd998244351, 32'h8000_0000, 32'h5555_5555,
            32'hAAAA_AAAA
        };
        // zero exponent on zero and on the prime itself, then prime bases with live exponents,
        // fermat's little theorem and the inverse, and the widest fields
        for (int k = 0; k < 21; k++) begin
            send_power(bases[k], expos[k]);
        end
        pause_sender(1);
    endtask

    // the receiver holds off for a long stretch while transactions keep coming
    task automatic test_result_backpressure();
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < BACKLOG_ITEMS; k++) begin
            send_power(random_base(), random_exponent());
        end
        pause_sender(1);
    endtask

    // bursts of random length with random gaps, some of them back to back
    task automatic test_random_powers(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_power(random_base(), random_exponent());
                sent++;
            end
            case ($urandom_range(0, 3))
                0: ;
                1: pause_sender($urandom_range(1, 20));
                default: pause_sender($urandom_range(1, MAX_GAP));
            endcase
        end
        pause_sender(1);
    endtask

    // wait until every expected residue has come, then let the pipeline settle
    task automatic drain_results();
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result checker: results are popped before the same cycle's input is queued
    always @(posedge aclk) begin
        power_case_t head;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_powers.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result transaction, expected none, actual %0d",
                             $time, m_power_residue);
                end else begin
                    head = pending_powers.pop_front();
                    if (m_power_residue !== head.residue) begin
                        mismatch_count++;
                        $display("%0t: power_residue for %0d^%0d: expected %0d, actual %0d",
                                 $time, head.base, head.expo, head.residue,
                                 m_power_residue);
                    end
                end
            end
            if (s_valid && s_ready) begin
                head.base      = s_base_value;
                head.expo      = s_exponent_value;
                head.residue   = power_mod_prime(s_base_value, s_exponent_value);
                pending_powers = {pending_powers, head};
            end
        end
    end

    // receiver: changes its stall behaviour in phases, and serves long hold-off requests
    always @(posedge aclk) begin
        int          hold_left;
        int          phase_left;
        int          rx_mode;
        int unsigned rx_tick;
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_mode    = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 400);
            end else begin
                phase_left--;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) != 0);
                2: m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_powers();
        test_result_backpressure();
        test_random_powers(RANDOM_ITEMS);
        drain_results();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
